// ===== src/bfba_pkg.sv =====
// Shared types and constants of the best-fit block allocator.
`timescale 1ns / 1ps

package bfba_pkg;

	// Fixed widths of the item and result fields.
	localparam int FUNC_W = 1;
	localparam int IDX_W  = 6;
	localparam int SIZE_W = 16;

	// Configuration register.
	localparam int       NB_W           = 7;
	localparam logic [NB_W-1:0] NUM_BLOCKS_RST = 7'd64;
	localparam int       APB_ADDR_W     = 3;
	localparam int       APB_DATA_W     = 32;
	localparam logic     REG_NUM_BLOCKS = 1'b0;

	// Item function codes.
	localparam logic [FUNC_W-1:0] FUNC_LOAD    = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_REQUEST = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// ===== src/bfba_item_if.sv =====
// Valid/ready channel that carries load and request items.
`timescale 1ns / 1ps

interface bfba_item_if;
	logic                          valid;
	logic                          ready;
	logic [bfba_pkg::FUNC_W-1:0]   func;
	logic [bfba_pkg::IDX_W-1:0]    block_index;
	logic [bfba_pkg::SIZE_W-1:0]   size;

	modport source (output valid, func, block_index, size, input ready);
	modport sink (input valid, func, block_index, size, output ready);
endinterface

// ===== src/bfba_result_if.sv =====
// Valid/ready channel that carries allocation results.
`timescale 1ns / 1ps

interface bfba_result_if;
	logic                          valid;
	logic                          ready;
	logic                          allocated;
	logic [bfba_pkg::IDX_W-1:0]    chosen_block;
	logic [bfba_pkg::SIZE_W-1:0]   leftover;

	modport source (output valid, allocated, chosen_block, leftover, input ready);
	modport sink (input valid, allocated, chosen_block, leftover, output ready);
endinterface

// ===== src/bfba_ram.sv =====
// Simple dual-port synchronous RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bfba_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/bfba_apb.sv =====
// APB register slave that holds the num_blocks setting.
`timescale 1ns / 1ps

module bfba_apb (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bfba_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [bfba_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [bfba_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output logic [bfba_pkg::NB_W-1:0]           num_blocks
);

	logic [bfba_pkg::NB_W-1:0] num_blocks_q;
	logic                      sel_nb;

	// Registers are word aligned, so bit 2 is the register index.
	assign sel_nb = (paddr[2] == bfba_pkg::REG_NUM_BLOCKS);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_blocks_q <= bfba_pkg::NUM_BLOCKS_RST;
		end else if (psel && penable && pwrite && sel_nb) begin
			num_blocks_q <= pwdata[bfba_pkg::NB_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_nb) begin
			prdata = bfba_pkg::APB_DATA_W'(num_blocks_q);
		end
	end

	assign num_blocks = num_blocks_q;

endmodule

// ===== src/bfba_ctrl.sv =====
// Sequencer that clears, loads and scans the block table and holds the result.
`timescale 1ns / 1ps

module bfba_ctrl #(
	parameter int MAX_BLOCKS = 64,
	parameter int SIZE_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bfba_pkg::NB_W-1:0]     num_blocks,
	bfba_item_if.sink                     item,
	bfba_result_if.source                 result,
	output logic                          ram_we,
	output logic [$clog2(MAX_BLOCKS)-1:0] ram_waddr,
	output logic [SIZE_BITS:0]            ram_wdata,
	output logic                          ram_re,
	output logic [$clog2(MAX_BLOCKS)-1:0] ram_raddr,
	input  logic [SIZE_BITS:0]            ram_rdata
);

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int LW = (CW > bfba_pkg::NB_W) ? CW : bfba_pkg::NB_W;

	bfba_pkg::state_t state_q, state_d;

	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        limit;
	logic [LW-1:0]        nb_ext;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic [SIZE_BITS-1:0] req_size_q;
	logic                 found_q;
	logic [AW-1:0]        best_idx_q;
	logic [SIZE_BITS-1:0] best_left_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic                 out_valid_q;
	logic                 out_alloc_q;
	logic [bfba_pkg::IDX_W-1:0]  out_blk_q;
	logic [bfba_pkg::SIZE_W-1:0] out_left_q;

	logic                 item_xfer;
	logic                 finish;
	logic                 in_range;
	logic [SIZE_BITS-1:0] size_in;
	logic                 entry_used;
	logic [SIZE_BITS-1:0] entry_size;
	logic [SIZE_BITS-1:0] entry_left;
	logic                 take;

	assign nb_ext   = LW'(num_blocks);
	assign limit    = (nb_ext > LW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(nb_ext);
	assign size_in  = SIZE_BITS'(item.size);
	assign in_range = (32'(item.block_index) < 32'(MAX_BLOCKS));
	assign item_xfer = item.valid && item.ready;

	assign entry_used = ram_rdata[SIZE_BITS];
	assign entry_size = ram_rdata[SIZE_BITS-1:0];
	assign entry_left = entry_size - req_size_q;
	// Later blocks win ties, so an equal leftover replaces the current best.
	assign take = rd_vld_s1 && !entry_used && (entry_size >= req_size_q)
		&& (!found_q || (entry_left <= best_left_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfba_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = cnt_q[AW-1:0];
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = cnt_q[AW-1:0];
		finish     = 1'b0;
		unique case (state_q)
			bfba_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (cnt_q == CW'(MAX_BLOCKS - 1)) begin
					state_d = bfba_pkg::ST_IDLE;
				end
			end
			bfba_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					if (item.func == bfba_pkg::FUNC_LOAD) begin
						ram_we    = in_range;
						ram_waddr = AW'(item.block_index);
						ram_wdata = {1'b0, size_in};
					end else begin
						state_d = bfba_pkg::ST_SCAN;
					end
				end
			end
			bfba_pkg::ST_SCAN: begin
				if (cnt_q < limit) begin
					ram_re = 1'b1;
				end else if (!rd_vld_s1) begin
					state_d = bfba_pkg::ST_DONE;
				end
			end
			bfba_pkg::ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					finish    = 1'b1;
					ram_we    = found_q;
					ram_waddr = best_idx_q;
					ram_wdata = {1'b1, best_size_q};
					state_d   = bfba_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			if (state_q == bfba_pkg::ST_CLEAR) begin
				cnt_q <= (state_d == bfba_pkg::ST_IDLE) ? '0 : cnt_q + 1'b1;
			end else if (item_xfer && item.func == bfba_pkg::FUNC_REQUEST) begin
				cnt_q <= '0;
			end else if (ram_re) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (item_xfer && item.func == bfba_pkg::FUNC_REQUEST) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[AW-1:0];
		if (item_xfer && item.func == bfba_pkg::FUNC_REQUEST) begin
			req_size_q <= size_in;
		end
		if (take) begin
			best_idx_q  <= rd_idx_s1;
			best_left_q <= entry_left;
			best_size_q <= entry_size;
		end
	end

	// The result register frees the scan logic while a result waits for transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_alloc_q <= found_q;
			out_blk_q   <= found_q ? bfba_pkg::IDX_W'(best_idx_q) : '0;
			out_left_q  <= found_q ? bfba_pkg::SIZE_W'(best_left_q) : '0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.allocated    = out_alloc_q;
	assign result.chosen_block = out_blk_q;
	assign result.leftover     = out_left_q;

endmodule

// ===== src/best_fit_block_allocator_top.sv =====
// Top level of the best-fit block allocator.
`timescale 1ns / 1ps

// Best-fit block allocator. Block sizes and used marks share one table RAM
// with a registered read. A load item writes one entry and gives no result,
// so loads can follow each other on every cycle. A request reads the first
// L = min(num_blocks, MAX_BLOCKS) entries one per cycle through the RAM read
// port, waits for the last read to come back and be compared, then marks the
// winner used and loads the result register. The input is not ready from
// when a request is taken until the result register is loaded. With
// num_blocks at zero nothing is read. The final step is held while an
// earlier result still waits for its transfer. After reset the block clears
// the table and takes no item meanwhile; APB writes are taken at any time.

module best_fit_block_allocator_top #(
	parameter int MAX_BLOCKS = 64,
	parameter int SIZE_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	bfba_item_if.sink                           item,
	bfba_result_if.source                       result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bfba_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [bfba_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [bfba_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int AW = $clog2(MAX_BLOCKS);

	logic [bfba_pkg::NB_W-1:0] num_blocks;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [SIZE_BITS:0]        ram_wdata;
	logic                      ram_re;
	logic [AW-1:0]             ram_raddr;
	logic [SIZE_BITS:0]        ram_rdata;

	bfba_apb u_apb (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.num_blocks (num_blocks)
	);

	bfba_ram #(
		.DEPTH (MAX_BLOCKS),
		.WIDTH (SIZE_BITS + 1)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bfba_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_blocks (num_blocks),
		.item       (item),
		.result     (result),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

endmodule
